// File: rtl/core/cgca_pkg.sv
// Shared types and constants for the constraint graph color assigner.
// No dependencies; every other file in rtl/core imports this package.
package cgca_pkg;

  // Fixed field widths of the request and response channels
  localparam int BODY_W = 10;
  localparam int SLOT_W = 4;

  // Defaults for the top-level parameters
  localparam int NUM_COLORS_DEF = 12;
  localparam int MAX_BODIES_DEF = 1024;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic clear;    // zero one mask entry of the clear sweep
    logic load;     // capture request, read both body masks
    logic write_a;  // pick color, write body A mask
    logic write_b;  // write body B mask, load response register
  } cgca_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic clear_done;  // clear sweep is on its last entry
  } cgca_sts_t;

endpackage

// File: rtl/core/cgca_if.sv
// Valid/ready channel interfaces for requests and responses.
// Depends on cgca_pkg for field widths.
interface cgca_req_if;
  import cgca_pkg::*;

  logic              valid;
  logic              ready;
  logic              command;
  logic [BODY_W-1:0] body_a;
  logic [BODY_W-1:0] body_b;
  logic              static_a;
  logic              static_b;
  logic              is_contact;
  logic [SLOT_W-1:0] color_slot;

  modport source (
    output valid, command, body_a, body_b, static_a, static_b, is_contact, color_slot,
    input  ready
  );
  modport sink (
    input  valid, command, body_a, body_b, static_a, static_b, is_contact, color_slot,
    output ready
  );
endinterface

interface cgca_rsp_if;
  import cgca_pkg::*;

  logic              valid;
  logic              ready;
  logic [SLOT_W-1:0] color_index;
  logic              went_overflow;

  modport source (output valid, color_index, went_overflow, input ready);
  modport sink   (input valid, color_index, went_overflow, output ready);
endinterface

// File: rtl/core/cgca_ctrl.sv
// Controller FSM: clear sweep, request accept, two mask writes, response hand-off.
// Depends on cgca_pkg for the command and status structs.
module cgca_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                req_valid,
  output logic                req_ready,
  output logic                rsp_valid,
  input  logic                rsp_ready,
  input  cgca_pkg::cgca_sts_t sts,
  output cgca_pkg::cgca_cmd_t cmd
);
  import cgca_pkg::*;

  localparam logic [1:0] ST_CLEAR   = 2'd0;
  localparam logic [1:0] ST_IDLE    = 2'd1;
  localparam logic [1:0] ST_WRITE_A = 2'd2;
  localparam logic [1:0] ST_WRITE_B = 2'd3;

  logic [1:0] state;
  logic [1:0] state_next;
  logic       out_free;

  // response register can take a new transaction
  assign out_free  = !rsp_valid || rsp_ready;
  assign req_ready = (state == ST_IDLE);

  // next state and commands
  always_comb begin
    state_next  = state;
    cmd         = '0;
    case (state)
      ST_CLEAR: begin
        cmd.clear = 1'b1;
        if (sts.clear_done) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (req_valid) begin
          cmd.load   = 1'b1;
          state_next = ST_WRITE_A;
        end
      end
      ST_WRITE_A: begin
        cmd.write_a = 1'b1;
        state_next  = ST_WRITE_B;
      end
      ST_WRITE_B: begin
        if (out_free) begin
          cmd.write_b = 1'b1;
          state_next  = ST_IDLE;
        end
      end
      default: state_next = ST_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // response valid
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (cmd.write_b) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

endmodule

// File: rtl/core/cgca_dpath.sv
// Datapath: per-body color mask memory, clear counter, lowest-free color pick.
// Depends on cgca_pkg for field widths and the command and status structs.
module cgca_dpath #(
  parameter int NUM_COLORS = cgca_pkg::NUM_COLORS_DEF,
  parameter int MAX_BODIES = cgca_pkg::MAX_BODIES_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  cgca_pkg::cgca_cmd_t         cmd,
  output cgca_pkg::cgca_sts_t         sts,
  input  logic                        command,
  input  logic [cgca_pkg::BODY_W-1:0] body_a,
  input  logic [cgca_pkg::BODY_W-1:0] body_b,
  input  logic                        static_a,
  input  logic                        static_b,
  input  logic                        is_contact,
  input  logic [cgca_pkg::SLOT_W-1:0] color_slot,
  output logic [cgca_pkg::SLOT_W-1:0] color_index,
  output logic                        went_overflow
);
  import cgca_pkg::*;

  localparam int AW = (MAX_BODIES > 1) ? $clog2(MAX_BODIES) : 1;
  localparam int NW = NUM_COLORS;
  localparam int CW = $clog2(NUM_COLORS + 1);

  logic [NW-1:0] mem [MAX_BODIES];

  // captured request
  logic              q_cmd;
  logic [BODY_W-1:0] q_a;
  logic [BODY_W-1:0] q_b;
  logic              q_sa;
  logic              q_sb;
  logic              q_contact;
  logic [SLOT_W-1:0] q_slot;
  logic              q_va;
  logic              q_vb;
  logic [NW-1:0]     rd_a;
  logic [NW-1:0]     rd_b;

  // values held between the A and B writes
  logic [NW-1:0]     pend_b_mask;
  logic              pend_b_we;
  logic [SLOT_W-1:0] pend_color;
  logic              pend_ovf;

  logic [AW-1:0]     clr_ptr;

  // combinational color pick
  logic [NW-1:0] marks_a;
  logic [NW-1:0] marks_b;
  logic [NW-1:0] busy;
  logic [NW-1:0] start_mask;
  logic [NW-1:0] free_bits;
  logic [NW-1:0] low_bit;
  logic [CW-1:0] low_idx;
  logic          found;
  logic [NW-1:0] rm_bit;
  logic          slot_ok;
  logic [NW-1:0] new_a;
  logic [NW-1:0] new_b;
  logic          we_a;
  logic          we_b;
  logic [CW-1:0] add_color;
  logic [SLOT_W-1:0] res_color;
  logic          res_ovf;

  // memory write port
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [NW-1:0] wr_data;

  assign sts.clear_done = (clr_ptr == AW'(MAX_BODIES - 1));

  // clear sweep pointer
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_ptr <= '0;
    end else if (cmd.clear) begin
      clr_ptr <= clr_ptr + AW'(1);
    end
  end

  // capture request and read both masks
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      q_cmd     <= command;
      q_a       <= body_a;
      q_b       <= body_b;
      q_sa      <= static_a;
      q_sb      <= static_b;
      q_contact <= is_contact;
      q_slot    <= color_slot;
      q_va      <= (32'(body_a) < MAX_BODIES);
      q_vb      <= (32'(body_b) < MAX_BODIES);
      rd_a      <= mem[AW'(body_a)];
      rd_b      <= mem[AW'(body_b)];
    end
  end

  // lowest free color and remove mask
  always_comb begin
    marks_a    = q_va ? rd_a : '0;
    marks_b    = q_vb ? rd_b : '0;
    busy       = (q_sa ? '0 : marks_a) | (q_sb ? '0 : marks_b);
    start_mask = '1;
    if ((q_sa || q_sb) && q_contact) start_mask[0] = 1'b0;
    free_bits  = ~busy & start_mask;
    low_bit    = free_bits & (~free_bits + NW'(1));
    found      = |free_bits;
    low_idx    = '0;
    for (int c = 0; c < NW; c++) begin
      if (low_bit[c]) low_idx = low_idx | CW'(c);
    end
    for (int c = 0; c < NW; c++) begin
      rm_bit[c] = (32'(q_slot) == c);
    end
    slot_ok = (32'(q_slot) < NUM_COLORS);
  end

  // new masks, enables and response value
  always_comb begin
    if (q_cmd) begin
      new_a     = marks_a & ~rm_bit;
      new_b     = marks_b & ~rm_bit;
      we_a      = q_va && slot_ok;
      we_b      = q_vb && slot_ok;
      add_color = '0;
      res_color = q_slot;
      res_ovf   = (32'(q_slot) == NUM_COLORS);
    end else begin
      new_a     = marks_a | low_bit;
      new_b     = marks_b | low_bit;
      we_a      = q_va && !q_sa && found;
      we_b      = q_vb && !q_sb && found;
      add_color = (found && !(q_sa && q_sb)) ? low_idx : CW'(NUM_COLORS);
      res_color = SLOT_W'(add_color);
      res_ovf   = (add_color == CW'(NUM_COLORS));
    end
  end

  // hold B write and response until the write slot
  always_ff @(posedge clk) begin
    if (cmd.write_a) begin
      pend_b_mask <= new_b;
      pend_b_we   <= we_b;
      pend_color  <= res_color;
      pend_ovf    <= res_ovf;
    end
  end

  // write port select
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = clr_ptr;
    wr_data = '0;
    if (cmd.clear) begin
      wr_en = 1'b1;
    end else if (cmd.write_a) begin
      wr_en   = we_a;
      wr_addr = AW'(q_a);
      wr_data = new_a;
    end else if (cmd.write_b) begin
      wr_en   = pend_b_we;
      wr_addr = AW'(q_b);
      wr_data = pend_b_mask;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // response register
  always_ff @(posedge clk) begin
    if (cmd.write_b) begin
      color_index   <= pend_color;
      went_overflow <= pend_ovf;
    end
  end

endmodule

// File: rtl/core/constraint_graph_color_assigner.sv
// Top level of the constraint graph color assigner: controller plus datapath.
// Depends on cgca_pkg, cgca_if, cgca_ctrl and cgca_dpath.
//
//   channel | dir | handshake    | payload
//   req     | in  | valid/ready  | command, body_a, body_b, static_a, static_b,
//           |     |              | is_contact, color_slot
//   rsp     | out | valid/ready  | color_index, went_overflow
//
// Each transaction goes through these steps in order: accept with both mask reads, write of body A's
// mask, then write of body B's mask with the response register load. The single
// write port of the mask memory keeps the two writes apart.
// After reset the block sweeps the mask memory to zero, entry by entry, with
// req.ready low. A stalled response holds the block in its last step; one
// response can wait in the output register while the next request is taken.
module constraint_graph_color_assigner #(
  parameter int NUM_COLORS = cgca_pkg::NUM_COLORS_DEF,
  parameter int MAX_BODIES = cgca_pkg::MAX_BODIES_DEF
) (
  input logic          clk,
  input logic          rst,
  cgca_req_if.sink     req,
  cgca_rsp_if.source   rsp
);
  import cgca_pkg::*;

  cgca_cmd_t cmd;
  cgca_sts_t sts;

  cgca_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .rsp_valid (rsp.valid),
    .rsp_ready (rsp.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  cgca_dpath #(
    .NUM_COLORS (NUM_COLORS),
    .MAX_BODIES (MAX_BODIES)
  ) u_dpath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .sts           (sts),
    .command       (req.command),
    .body_a        (req.body_a),
    .body_b        (req.body_b),
    .static_a      (req.static_a),
    .static_b      (req.static_b),
    .is_contact    (req.is_contact),
    .color_slot    (req.color_slot),
    .color_index   (rsp.color_index),
    .went_overflow (rsp.went_overflow)
  );

  // no request taken during the clear sweep
  assert property (@(posedge clk) disable iff (rst) cmd.clear |-> !req.ready)
    else $error("request ready during clear sweep");

  // an accepted request goes straight to the A write
  assert property (@(posedge clk) disable iff (rst) (req.valid && req.ready) |=> cmd.write_a)
    else $error("accepted request did not start the A write");

  // the response register is loaded only when it is free
  assert property (@(posedge clk) disable iff (rst) cmd.write_b |-> (!rsp.valid || rsp.ready))
    else $error("response overwritten while waiting");

  // datapath commands are mutually exclusive
  assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.clear, cmd.load, cmd.write_a, cmd.write_b}))
    else $error("more than one datapath command");

endmodule
